/* design/etlca_pkg.sv */
// Shared types and constants for the elimination-tree leaf and LCA finder.
package etlca_pkg;

    localparam int unsigned IDX_W = 10;
    localparam int unsigned CA_W  = 11;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_SET   = 1'b1;

    localparam logic [1:0] LEAF_NONE  = 2'd0;
    localparam logic [1:0] LEAF_FIRST = 2'd1;
    localparam logic [1:0] LEAF_LATER = 2'd2;

    localparam logic signed [CA_W-1:0] NO_ANCESTOR = -11'sd1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ROW   = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // One row entry: largest first descendant so far and the previous leaf.
    typedef struct packed {
        logic signed [CA_W-1:0] max_first;
        logic signed [CA_W-1:0] prev_leaf;
    } row_entry_t;

    typedef struct packed {
        logic is_leaf;
        logic first_leaf;
    } row_status_t;

endpackage

/* design/etree_leaf_lca_finder_top.sv */
// Top level of the elimination-tree leaf test and least-common-ancestor finder.
//
// Input channel (in_valid / in_stall) carries one beat per item: a leaf query
// (kind 0: row_index, node_index, first_descendant) or an ancestor write
// (kind 1: node_index, parent_value). Output channel (out_valid / out_stall)
// returns exactly one beat per item: common_ancestor and leaf_kind.
// Items are processed one at a time; in_stall is low only when the sequencer
// is idle. A finished result sits in the output register, so the next item is
// taken while that beat still waits for the receiver.
// From acceptance to the output register: an ancestor write or a rejected
// query goes straight to the emit state; any other query reads its row entry
// and emits, unless it is a later leaf, which walks its links to the root and
// compresses that path before it emits. The sequencer returns to idle before
// the next item is taken.
// The walk and the path compression each read the link memory once per cycle,
// so the root distance sets the cost; compression keeps later walks short.
// After reset a clearing pass writes every row entry to "none" and every link
// to its own index, and in_stall stays high during the pass.
// When the receiver stalls with a result pending, the next item's result is
// held in the sequencer until the output register frees up.
module etree_leaf_lca_finder_top #(
    parameter int NODES = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  kind,
    input  logic [9:0]                            row_index,
    input  logic [9:0]                            node_index,
    input  logic [9:0]                            first_descendant,
    input  logic [9:0]                            parent_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [10:0]                    common_ancestor,
    output logic [1:0]                            leaf_kind
);

    localparam int AW = $clog2(NODES);
    localparam int SW = $clog2(NODES + 1);
    localparam logic [SW-1:0] STEP_LIMIT = SW'(NODES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(NODES - 1);

    etlca_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic [AW-1:0]                   row_reg, row_next;
    logic [etlca_pkg::IDX_W-1:0]     node_reg, node_next;
    logic [etlca_pkg::IDX_W-1:0]     first_reg, first_next;
    logic [etlca_pkg::IDX_W-1:0]     start_reg, start_next;
    logic [etlca_pkg::IDX_W-1:0]     q_reg, q_next;
    logic [etlca_pkg::IDX_W-1:0]     s_reg, s_next;
    logic [etlca_pkg::IDX_W-1:0]     root_reg, root_next;
    logic [SW-1:0]                   steps_reg, steps_next;
    logic signed [etlca_pkg::CA_W-1:0] res_ca_reg, res_ca_next;
    logic [1:0]                      res_kind_reg, res_kind_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [etlca_pkg::CA_W-1:0] out_ca_reg, out_ca_next;
    logic [1:0]                      out_kind_reg, out_kind_next;

    logic                            row_wr_en;
    logic [AW-1:0]                   row_wr_addr;
    etlca_pkg::row_entry_t           row_wr_data;
    logic [AW-1:0]                   row_rd_addr;
    etlca_pkg::row_status_t          row_status;
    logic [etlca_pkg::IDX_W-1:0]     prev_node;

    logic                            link_wr_en;
    logic [AW-1:0]                   link_wr_addr;
    logic [etlca_pkg::IDX_W-1:0]     link_wr_data;
    logic [AW-1:0]                   link_rd_addr;
    logic [etlca_pkg::IDX_W-1:0]     link_q;

    logic                            accept;
    logic                            row_ok;
    logic                            node_ok;
    logic                            parent_ok;
    logic                            out_free;
    logic                            walk_done;
    logic                            cmp_done;

    etlca_row_store #(
        .NODES (NODES)
    ) u_row_store (
        .clk       (clk),
        .wr_en     (row_wr_en),
        .wr_addr   (row_wr_addr),
        .wr_data   (row_wr_data),
        .rd_addr   (row_rd_addr),
        .first     (first_reg),
        .status    (row_status),
        .prev_node (prev_node)
    );

    etlca_forest #(
        .NODES (NODES)
    ) u_forest (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_addr (link_rd_addr),
        .rd_data (link_q)
    );

    assign in_stall  = (state_reg != etlca_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign row_ok    = 32'(row_index) < NODES;
    assign node_ok   = 32'(node_index) < NODES;
    assign parent_ok = 32'(parent_value) < NODES;
    assign out_free  = !out_valid_reg || !out_stall;

    // Stop the walk at a self-linked entry or after NODES links.
    assign walk_done = (steps_reg == STEP_LIMIT) || (link_q == q_reg);
    assign cmp_done  = (steps_reg == STEP_LIMIT) || (s_reg == root_reg);

    // Memory address and write selection.
    always_comb
    begin
        row_rd_addr  = AW'(row_index);
        row_wr_en    = 1'b0;
        row_wr_addr  = row_reg;
        row_wr_data.max_first = {1'b0, first_reg};
        row_wr_data.prev_leaf = {1'b0, node_reg};
        link_wr_en   = 1'b0;
        link_wr_addr = AW'(s_reg);
        link_wr_data = root_reg;
        link_rd_addr = AW'(link_q);

        unique case (state_reg)
            etlca_pkg::ST_CLEAR:
            begin
                row_wr_en             = 1'b1;
                row_wr_addr           = clr_addr_reg;
                row_wr_data.max_first = etlca_pkg::NO_ANCESTOR;
                row_wr_data.prev_leaf = etlca_pkg::NO_ANCESTOR;
                link_wr_en            = 1'b1;
                link_wr_addr          = clr_addr_reg;
                link_wr_data          = etlca_pkg::IDX_W'(clr_addr_reg);
            end
            etlca_pkg::ST_IDLE:
            begin
                link_wr_en   = accept && (kind == etlca_pkg::KIND_SET) && node_ok && parent_ok;
                link_wr_addr = AW'(node_index);
                link_wr_data = parent_value;
            end
            etlca_pkg::ST_ROW:
            begin
                row_wr_en    = row_status.is_leaf;
                link_rd_addr = AW'(prev_node);
            end
            etlca_pkg::ST_WALK:
            begin
                link_rd_addr = walk_done ? AW'(start_reg) : AW'(link_q);
            end
            etlca_pkg::ST_CMP:
            begin
                link_wr_en = !cmp_done;
            end
            etlca_pkg::ST_EMIT:
            begin
                link_rd_addr = AW'(link_q);
            end
            default:
            begin
                link_rd_addr = AW'(link_q);
            end
        endcase
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        row_next       = row_reg;
        node_next      = node_reg;
        first_next     = first_reg;
        start_next     = start_reg;
        q_next         = q_reg;
        s_next         = s_reg;
        root_next      = root_reg;
        steps_next     = steps_reg;
        res_ca_next    = res_ca_reg;
        res_kind_next  = res_kind_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_ca_next    = out_ca_reg;
        out_kind_next  = out_kind_reg;

        unique case (state_reg)
            etlca_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = etlca_pkg::ST_IDLE;
                end
            end
            etlca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    row_next      = AW'(row_index);
                    node_next     = node_index;
                    first_next    = first_descendant;
                    res_ca_next   = etlca_pkg::NO_ANCESTOR;
                    res_kind_next = etlca_pkg::LEAF_NONE;
                    if ((kind == etlca_pkg::KIND_QUERY) && row_ok && node_ok &&
                        (row_index > node_index))
                    begin
                        state_next = etlca_pkg::ST_ROW;
                    end
                    else
                    begin
                        state_next = etlca_pkg::ST_EMIT;
                    end
                end
            end
            etlca_pkg::ST_ROW:
            begin
                if (!row_status.is_leaf)
                begin
                    state_next = etlca_pkg::ST_EMIT;
                end
                else if (row_status.first_leaf)
                begin
                    res_ca_next   = signed'({1'b0, etlca_pkg::IDX_W'(row_reg)});
                    res_kind_next = etlca_pkg::LEAF_FIRST;
                    state_next    = etlca_pkg::ST_EMIT;
                end
                else
                begin
                    start_next = prev_node;
                    q_next     = prev_node;
                    steps_next = '0;
                    state_next = etlca_pkg::ST_WALK;
                end
            end
            etlca_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    root_next  = q_reg;
                    s_next     = start_reg;
                    steps_next = '0;
                    state_next = etlca_pkg::ST_CMP;
                end
                else
                begin
                    q_next     = link_q;
                    steps_next = steps_reg + SW'(1);
                end
            end
            etlca_pkg::ST_CMP:
            begin
                if (cmp_done)
                begin
                    res_ca_next   = signed'({1'b0, root_reg});
                    res_kind_next = etlca_pkg::LEAF_LATER;
                    state_next    = etlca_pkg::ST_EMIT;
                end
                else
                begin
                    s_next     = link_q;
                    steps_next = steps_reg + SW'(1);
                end
            end
            etlca_pkg::ST_EMIT:
            begin
                // Hold the result until the output register frees up.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ca_next    = res_ca_reg;
                    out_kind_next  = res_kind_reg;
                    state_next     = etlca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etlca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etlca_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        node_reg     <= node_next;
        first_reg    <= first_next;
        start_reg    <= start_next;
        q_reg        <= q_next;
        s_reg        <= s_next;
        root_reg     <= root_next;
        res_ca_reg   <= res_ca_next;
        res_kind_reg <= res_kind_next;
        out_ca_reg   <= out_ca_next;
        out_kind_reg <= out_kind_next;
    end

    assign out_valid       = out_valid_reg;
    assign common_ancestor = out_ca_reg;
    assign leaf_kind       = out_kind_reg;

    a_none_has_no_ancestor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == etlca_pkg::LEAF_NONE)) |->
            (out_ca_reg == etlca_pkg::NO_ANCESTOR)
    ) else $error("not-a-leaf result carries an ancestor");

    a_leaf_has_node: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != etlca_pkg::LEAF_NONE)) |->
            !out_ca_reg[etlca_pkg::CA_W-1]
    ) else $error("leaf result carries a negative ancestor");

    a_walk_no_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == etlca_pkg::ST_WALK) |-> !link_wr_en
    ) else $error("link memory written during root walk");

    a_step_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == etlca_pkg::ST_WALK) || (state_reg == etlca_pkg::ST_CMP)) |->
            (steps_reg <= STEP_LIMIT)
    ) else $error("walk step count past node count");

    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != etlca_pkg::ST_IDLE)
    ) else $error("item accepted without leaving idle");

endmodule

/* design/etlca_row_store.sv */
// Per-row memory of max first descendant and previous leaf, with the leaf test.
module etlca_row_store #(
    parameter int NODES = 1024
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(NODES)-1:0]          wr_addr,
    input  etlca_pkg::row_entry_t             wr_data,
    input  logic [$clog2(NODES)-1:0]          rd_addr,
    input  logic [etlca_pkg::IDX_W-1:0]       first,
    output etlca_pkg::row_status_t            status,
    output logic [etlca_pkg::IDX_W-1:0]       prev_node
);

    etlca_pkg::row_entry_t mem [NODES];
    etlca_pkg::row_entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    // Leaf when nothing recorded yet or first exceeds the recorded maximum.
    always_comb
    begin
        status.is_leaf    = q_reg.max_first[etlca_pkg::CA_W-1] |
                            (first > q_reg.max_first[etlca_pkg::IDX_W-1:0]);
        status.first_leaf = q_reg.prev_leaf[etlca_pkg::CA_W-1];
        prev_node         = q_reg.prev_leaf[etlca_pkg::IDX_W-1:0];
    end

endmodule

/* design/etlca_forest.sv */
// Ancestor link memory with write-to-read forwarding.
module etlca_forest #(
    parameter int NODES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [$clog2(NODES)-1:0]          wr_addr,
    input  logic [etlca_pkg::IDX_W-1:0]       wr_data,
    input  logic [$clog2(NODES)-1:0]          rd_addr,
    output logic [etlca_pkg::IDX_W-1:0]       rd_data
);

    logic [etlca_pkg::IDX_W-1:0] mem [NODES];
    logic [etlca_pkg::IDX_W-1:0] q_reg;
    logic [etlca_pkg::IDX_W-1:0] fwd_data_reg;
    logic                        fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg        <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // Flag a read that collides with a same-cycle write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

/* tb/tb_etree_leaf_lca_finder_top.sv */
// Self-checking testbench for the elimination-tree leaf test and LCA finder.
`timescale 1ns / 1ps

module tb_etree_leaf_lca_finder_top;
    import etlca_pkg::*;

    localparam int NODES         = 1024;
    localparam int PHASE_ITEMS   = 440;
    localparam int WINDOW        = 64;
    localparam int HOLD_CYCLES   = 300;

    // Predicts leaf kind and least common ancestor per accepted beat and
    // checks result beats against them in order.
    class leaf_lca_board;
        typedef struct packed {
            logic signed [CA_W-1:0] ancestor;
            logic [1:0]             leaf;
        } lca_answer_t;

        logic signed [CA_W-1:0] max_first [NODES];
        logic signed [CA_W-1:0] prev_leaf [NODES];
        logic [IDX_W-1:0]       link [NODES];
        lca_answer_t            answers_due[$];
        int                     errors;

        function new();
            for (int k = 0; k < NODES; k++)
            begin
                max_first[k] = NO_ANCESTOR;
                prev_leaf[k] = NO_ANCESTOR;
                link[k]      = IDX_W'(k);
            end
            errors = 0;
        endfunction

        function void note_item(logic k, logic [IDX_W-1:0] row, logic [IDX_W-1:0] node,
                                logic [IDX_W-1:0] first, logic [IDX_W-1:0] parent);
            lca_answer_t            ans;
            logic signed [CA_W-1:0] first_s;
            logic signed [CA_W-1:0] jprev;
            logic [IDX_W-1:0]       q;
            logic [IDX_W-1:0]       s;
            logic [IDX_W-1:0]       up;
            int                     steps;
            ans.ancestor = NO_ANCESTOR;
            ans.leaf     = LEAF_NONE;
            first_s      = {1'b0, first};
            if (k == KIND_SET)
            begin
                link[node] = parent;
            end
            else if (row > node && first_s > max_first[row])
            begin
                max_first[row] = first_s;
                jprev          = prev_leaf[row];
                prev_leaf[row] = {1'b0, node};
                if (jprev < 0)
                begin
                    ans.ancestor = {1'b0, row};
                    ans.leaf     = LEAF_FIRST;
                end
                else
                begin
                    // Walk to the root, giving up after NODES links on a cycle.
                    q     = jprev[IDX_W-1:0];
                    steps = 0;
                    while (steps < NODES && link[q] != q)
                    begin
                        q = link[q];
                        steps++;
                    end
                    // Point every link on the walked path straight at the root.
                    s     = jprev[IDX_W-1:0];
                    steps = 0;
                    while (steps < NODES && s != q)
                    begin
                        up      = link[s];
                        link[s] = q;
                        s       = up;
                        steps++;
                    end
                    ans.ancestor = {1'b0, q};
                    ans.leaf     = LEAF_LATER;
                end
            end
            answers_due.push_back(ans);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] MISMATCH %s", $realtime, what);
        endfunction

        function void check_result(logic signed [CA_W-1:0] ancestor, logic [1:0] leaf);
            lca_answer_t want;
            if (answers_due.size() == 0)
            begin
                flag($sformatf("unexpected result ancestor=%0d leaf_kind=%0d",
                               ancestor, leaf));
                return;
            end
            want = answers_due.pop_front();
            if (ancestor !== want.ancestor)
                flag($sformatf("common_ancestor expected %0d got %0d",
                               want.ancestor, ancestor));
            if (leaf !== want.leaf)
                flag($sformatf("leaf_kind expected %0d got %0d", want.leaf, leaf));
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   kind;
    logic [IDX_W-1:0]       row_index;
    logic [IDX_W-1:0]       node_index;
    logic [IDX_W-1:0]       first_descendant;
    logic [IDX_W-1:0]       parent_value;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [CA_W-1:0] common_ancestor;
    logic [1:0]             leaf_kind;

    leaf_lca_board board = new();

    // Idle percentages for the two sides; the main sequence changes them per phase.
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    // Set by the main sequence to make the receiver hold off for a long stretch.
    bit hold_req = 1'b0;
    // Base of the index window that well-formed traffic works in.
    int win_base = 0;

    etree_leaf_lca_finder_top #(
        .NODES(NODES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .row_index        (row_index),
        .node_index       (node_index),
        .first_descendant (first_descendant),
        .parent_value     (parent_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .common_ancestor  (common_ancestor),
        .leaf_kind        (leaf_kind)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one beat, idling first at the current rate, and hold it until taken.
    // Returns in the time step of the accepting edge, so the caller may drive
    // the next beat right away without lowering valid.
    task automatic send_beat(input logic k, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] node, input logic [IDX_W-1:0] first,
                             input logic [IDX_W-1:0] parent);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        kind             <= k;
        row_index        <= row;
        node_index       <= node;
        first_descendant <= first;
        parent_value     <= parent;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(k, row, node, first, parent);
    endtask

    // Leaf query shaped like the column-count pass: a row inside the window,
    // a node below it, and a first descendant just past the row's maximum.
    task automatic send_leaf_query();
        int r;
        int n;
        int mf;
        int lim;
        int f;
        r  = $urandom_range(win_base + 1, win_base + WINDOW - 1);
        n  = $urandom_range(win_base, r - 1);
        mf = int'(board.max_first[r]);
        if (mf < NODES - 1)
        begin
            lim = (NODES - 2 - mf < 7) ? NODES - 2 - mf : 7;
            f   = mf + 1 + $urandom_range(0, lim);
        end
        else
        begin
            f = $urandom_range(0, NODES - 1);
        end
        send_beat(KIND_QUERY, IDX_W'(r), IDX_W'(n), IDX_W'(f),
                  IDX_W'($urandom_range(0, NODES - 1)));
    endtask

    // Link writes keep parent >= node so the forest stays free of cycles and
    // walks stay short; cycles are covered by the directed part only.
    task automatic send_link_write(input bit in_window);
        int n;
        int p;
        if (in_window)
        begin
            n = $urandom_range(win_base, win_base + WINDOW - 2);
            p = ($urandom_range(0, 3) == 0) ? n : $urandom_range(n + 1, win_base + WINDOW - 1);
        end
        else
        begin
            n = $urandom_range(0, NODES - 1);
            p = $urandom_range(n, NODES - 1);
        end
        send_beat(KIND_SET, IDX_W'($urandom_range(0, NODES - 1)), IDX_W'(n),
                  IDX_W'($urandom_range(0, NODES - 1)), IDX_W'(p));
    endtask

    // Receiver: check each beat taken, then pick the stall for the next edge.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_result(common_ancestor, leaf_kind);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
            end
        end
    end

    initial
    begin : main_seq
        int roll;
        in_valid         = 1'b0;
        kind             = KIND_QUERY;
        row_index        = '0;
        node_index       = '0;
        first_descendant = '0;
        parent_value     = '0;
        out_stall        = 1'b0;
        rst_n            = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: rejected queries, first and later leaves, link writes at
        // the index extremes, and a cyclic ancestor chain.
        send_beat(KIND_QUERY, 10'd0, 10'd0, 10'd0, 10'd0);        // row not above node
        send_beat(KIND_QUERY, 10'd5, 10'd5, 10'd3, 10'd1023);     // row equal to node
        send_beat(KIND_QUERY, 10'd1023, 10'd0, 10'd0, 10'd0);     // first leaf
        send_beat(KIND_QUERY, 10'd1023, 10'd1, 10'd0, 10'd0);     // first not past max
        send_beat(KIND_SET, 10'd0, 10'd0, 10'd0, 10'd1);
        send_beat(KIND_SET, 10'd1023, 10'd1, 10'd1023, 10'd1023);
        send_beat(KIND_SET, 10'd0, 10'd1023, 10'd0, 10'd1023);    // self link
        send_beat(KIND_QUERY, 10'd1023, 10'd2, 10'd1023, 10'd0);  // later leaf, two-link walk
        send_beat(KIND_QUERY, 10'd1023, 10'd3, 10'd1023, 10'd0);  // equal to max
        send_beat(KIND_QUERY, 10'd10, 10'd4, 10'd5, 10'd0);
        send_beat(KIND_QUERY, 10'd10, 10'd7, 10'd6, 10'd0);       // previous leaf is a root
        send_beat(KIND_QUERY, 10'd10, 10'd8, 10'd7, 10'd0);
        send_beat(KIND_SET, 10'd0, 10'd20, 10'd0, 10'd21);        // two-entry cycle
        send_beat(KIND_SET, 10'd0, 10'd21, 10'd0, 10'd20);
        send_beat(KIND_QUERY, 10'd30, 10'd20, 10'd1, 10'd0);
        send_beat(KIND_QUERY, 10'd30, 10'd22, 10'd2, 10'd0);      // walk runs out on the cycle
        send_beat(KIND_SET, 10'd0, 10'd21, 10'd0, 10'd21);        // break the cycle
        send_beat(KIND_SET, 10'd0, 10'd20, 10'd0, 10'd20);
        send_beat(KIND_SET, 10'd0, 10'd1023, 10'd0, 10'd0);
        send_beat(KIND_SET, 10'd0, 10'd1023, 10'd0, 10'd1023);    // restore the root
        send_beat(KIND_QUERY, 10'd600, 10'd599, 10'd1023, 10'd0);
        send_beat(KIND_QUERY, 10'd600, 10'd598, 10'd1023, 10'd0);

        // Random phases: free-running, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 120 == 0)
                    win_base = $urandom_range(0, NODES - WINDOW);
                // Back-pressure: receiver holds off while the sender keeps offering.
                if (ph == 0 && i == 100)
                    hold_req = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    send_leaf_query();
                else if (roll < 78)
                    send_link_write(1'b1);
                else if (roll < 82)
                    send_link_write(1'b0);
                else
                    send_beat(KIND_QUERY, IDX_W'($urandom_range(0, NODES - 1)),
                              IDX_W'($urandom_range(0, NODES - 1)),
                              IDX_W'($urandom_range(0, NODES - 1)),
                              IDX_W'($urandom_range(0, NODES - 1)));
            end
        end
        in_valid <= 1'b0;

        // Drain, then give any stray beat time to show up.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        board.errors += board.pending();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
